// ----- sv/mhtq_pkg.sv -----
// Package for the min-heap expiry timer queue: payload types and codes.
package mhtq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned TimeW       = 48;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic MODE_SCHEDULE = 1'b0;
  localparam logic MODE_TICK     = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KeyW-1:0]  key_handle;
    logic [TimeW-1:0] expire_time;
    logic [TimeW-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KeyW-1:0]  expired_key;
    logic [TimeW-1:0] expired_time;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] t;
    logic [KeyW-1:0]  k;
  } entry_t;

  // a sorts strictly before b
  function automatic logic entry_before(entry_t a, entry_t b);
    logic r;
    if (a.t != b.t) r = (a.t < b.t);
    else r = (a.k < b.k);
    return r;
  endfunction

endpackage

// ----- sv/min_heap_expiry_timer_queue_unit.sv -----
// Min-heap expiry timer queue: heap memory, sift sequencer and output register.
// Schedule: the new entry climbs level by level while it sorts before its parent; full heap: rejected.
// Tick: reports NONE if no root is due, else pops each due root and sifts the last entry down from the root.
// The heap is one single-port-read memory; one shared compare unit orders entries.
// One item at a time; in_stall_o is high from acceptance until its last result leaves.
// rst_ni clears the entry count and control; heap contents are not cleared.
module min_heap_expiry_timer_queue_unit #(
  parameter int unsigned CAPACITY = mhtq_pkg::CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mhtq_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mhtq_pkg::out_item_t out_data_o
);
  import mhtq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;  // read parent
  localparam logic [3:0] S_UPCMP = 4'd2;  // compare with parent
  localparam logic [3:0] S_TOP   = 4'd3;  // read root
  localparam logic [3:0] S_TOPCK = 4'd4;  // root due?
  localparam logic [3:0] S_LASTR = 4'd5;  // read last entry
  localparam logic [3:0] S_LRD   = 4'd6;  // read left child
  localparam logic [3:0] S_RRD   = 4'd7;  // read right child
  localparam logic [3:0] S_DNCMP = 4'd8;  // pick and place
  localparam logic [3:0] S_OUT   = 4'd9;  // wait for result to drain

  logic [3:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] cidx_q, cidx_d;
  entry_t        cur_q, cur_d;
  entry_t        best_q, best_d;
  logic          bestc_q, bestc_d;
  logic [TimeW-1:0] now_q, now_d;
  logic          popped_q, popped_d;
  logic          ret_top_q, ret_top_d;
  out_item_t     out_q, out_d;
  logic          ov_q, ov_d;

  entry_t        mem [CAPACITY];
  entry_t        rd_q;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic          acc;
  logic          odone;
  logic          lt;
  logic          rwin;
  entry_t        cmp_a, cmp_b;
  logic [CW:0]   l_ix, r_ix;

  assign acc   = in_valid_i && !in_stall_o;
  assign odone = ov_q && !out_stall_i;
  assign cmp_a = (st_q == S_UPCMP) ? cur_q : rd_q;
  assign cmp_b = (st_q == S_UPCMP) ? rd_q : best_q;
  assign lt    = entry_before(cmp_a, cmp_b);
  assign l_ix  = (CW + 1)'({idx_q, 1'b1});
  assign r_ix  = l_ix + (CW + 1)'(1);
  assign rwin  = (r_ix < (CW + 1)'(cnt_q)) && lt;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; cidx_d = cidx_q;
    cur_d = cur_q; best_d = best_q; bestc_d = bestc_q; now_d = now_q;
    popped_d = popped_q; ret_top_d = ret_top_q; out_d = out_q;
    ov_d = ov_q && out_stall_i;
    we = 1'b0; wa = idx_q; wd = cur_q; ra = '0;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          popped_d = 1'b0;
          if (in_data_i.mode == MODE_SCHEDULE) begin
            if (cnt_q >= CW'(CAPACITY)) begin
              out_d = '{KIND_REJECTED, '0, '0, 1'b1};
              ov_d = 1'b1; ret_top_d = 1'b0; st_d = S_OUT;
            end else begin
              cur_d = '{in_data_i.expire_time, in_data_i.key_handle};
              idx_d = AW'(cnt_q);
              cnt_d = cnt_q + CW'(1);
              st_d = S_UPRD;
            end
          end else begin
            now_d = in_data_i.current_time;
            st_d = S_TOP;
          end
        end
      end
      S_UPRD: begin
        if (idx_q == '0) begin
          we = 1'b1;
          out_d = '{KIND_ACCEPTED, '0, '0, 1'b1};
          ov_d = 1'b1; ret_top_d = 1'b0; st_d = S_OUT;
        end else begin
          cidx_d = (idx_q - AW'(1)) >> 1;
          ra = (idx_q - AW'(1)) >> 1;
          st_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (lt) begin
          we = 1'b1; wd = rd_q;
          idx_d = cidx_q;
          st_d = S_UPRD;
        end else begin
          we = 1'b1;
          out_d = '{KIND_ACCEPTED, '0, '0, 1'b1};
          ov_d = 1'b1; ret_top_d = 1'b0; st_d = S_OUT;
        end
      end
      S_TOP: begin
        if (cnt_q == '0) begin
          out_d = '{KIND_NONE, '0, '0, 1'b1};
          if (popped_q) begin
            out_d = out_q; out_d.last = 1'b1;
          end
          ov_d = 1'b1; ret_top_d = 1'b0; st_d = S_OUT;
        end else begin
          ra = '0;
          st_d = S_TOPCK;
        end
      end
      S_TOPCK: begin
        if (rd_q.t <= now_q) begin
          if (popped_q) begin
            ov_d = 1'b1;
          end
          out_d = '{KIND_EXPIRED, rd_q.k, rd_q.t, 1'b0};
          popped_d = 1'b1;
          cnt_d = cnt_q - CW'(1);
          st_d = S_LASTR;
          if (popped_q) begin
            out_d = out_q;
            st_d = S_OUT; ret_top_d = 1'b1;
          end
        end else begin
          out_d = '{KIND_NONE, '0, '0, 1'b1};
          if (popped_q) begin
            out_d = out_q; out_d.last = 1'b1;
          end
          ov_d = 1'b1; ret_top_d = 1'b0; st_d = S_OUT;
        end
      end
      S_LASTR: begin
        ra = AW'(cnt_q);
        idx_d = '0;
        st_d = S_LRD;
        if (cnt_q == '0) st_d = S_TOP;
      end
      S_LRD: begin
        if (idx_q == '0 && !bestc_q) begin
          cur_d = rd_q;
        end
        bestc_d = 1'b1;
        best_d = (idx_q == '0 && !bestc_q) ? rd_q : cur_q;
        if (l_ix < (CW + 1)'(cnt_q)) begin
          ra = AW'(l_ix);
          st_d = S_RRD;
        end else begin
          we = 1'b1; wa = idx_q;
          wd = (idx_q == '0 && !bestc_q) ? rd_q : cur_q;
          bestc_d = 1'b0;
          st_d = S_TOP;
        end
      end
      S_RRD: begin
        cidx_d = idx_q;
        if (lt) begin
          best_d = rd_q; cidx_d = AW'(l_ix);
        end
        if (r_ix < (CW + 1)'(cnt_q)) begin
          ra = AW'(r_ix);
        end else begin
          ra = AW'(l_ix);
        end
        st_d = S_DNCMP;
      end
      S_DNCMP: begin
        we = 1'b1; wa = idx_q;
        if (rwin) begin
          wd = rd_q; idx_d = AW'(r_ix);
          best_d = cur_q;
          st_d = S_LRD;
        end else if (cidx_q == idx_q) begin
          wd = cur_q;
          bestc_d = 1'b0;
          st_d = S_TOP;
        end else begin
          wd = best_q; idx_d = cidx_q;
          best_d = cur_q;
          st_d = S_LRD;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          if (ret_top_q) begin
            ov_d = 1'b0;
            out_d = '{KIND_EXPIRED, rd_q.k, rd_q.t, 1'b0};
            ret_top_d = 1'b0;
            st_d = S_LASTR;
          end else if (!ov_q || odone) begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
      popped_q <= 1'b0;
      ret_top_q <= 1'b0;
      bestc_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
      popped_q <= popped_d;
      ret_top_q <= ret_top_d;
      bestc_q <= bestc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; cidx_q <= cidx_d; cur_q <= cur_d; best_q <= best_d;
    now_q <= now_d; out_q <= out_d;
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("entry count over capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(out_q)) else $error("result lost");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> in_stall_o) else $error("input taken during result");
`endif

endmodule

// ----- tb/sv/min_heap_expiry_timer_queue_unit_tb.sv -----
// Testbench for the min-heap expiry timer queue: directed and random items checked against a heap predictor.
module min_heap_expiry_timer_queue_unit_tb;
  import mhtq_pkg::*;

  localparam int unsigned Cap = CapacityDef;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  min_heap_expiry_timer_queue_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #10 clk_i = ~clk_i;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  entry_t timer_heap[Cap];
  int unsigned entry_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_sched = 0, n_reject = 0, n_expired = 0, n_none = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;

  function automatic bit heap_less(entry_t a, entry_t b);
    if (a.t != b.t) return a.t < b.t;
    return a.k < b.k;
  endfunction

  function automatic out_item_t mk_result(logic [1:0] kind, entry_t e, logic lst);
    out_item_t r;
    r.kind = kind;
    r.expired_key = e.k;
    r.expired_time = e.t;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_item(in_item_t it);
    entry_t e, tmp;
    out_item_t last_r;
    int unsigned i, p, l, r, m, n;
    if (it.mode == MODE_SCHEDULE) begin
      if (entry_cnt >= Cap) begin
        expected_results.push_back(mk_result(KIND_REJECTED, '0, 1'b1));
        n_reject++;
        return;
      end
      e.t = it.expire_time;
      e.k = it.key_handle;
      timer_heap[entry_cnt] = e;
      i = entry_cnt;
      entry_cnt++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!heap_less(timer_heap[i], timer_heap[p])) break;
        tmp = timer_heap[i]; timer_heap[i] = timer_heap[p]; timer_heap[p] = tmp;
        i = p;
      end
      expected_results.push_back(mk_result(KIND_ACCEPTED, '0, 1'b1));
      n_sched++;
      return;
    end
    n = 0;
    while (entry_cnt > 0 && timer_heap[0].t <= it.current_time && n < Cap) begin
      expected_results.push_back(mk_result(KIND_EXPIRED, timer_heap[0], 1'b0));
      n++;
      n_expired++;
      entry_cnt--;
      if (entry_cnt > 0) begin
        timer_heap[0] = timer_heap[entry_cnt];
        i = 0;
        forever begin
          l = 2 * i + 1;
          r = l + 1;
          m = i;
          if (l < entry_cnt && heap_less(timer_heap[l], timer_heap[m])) m = l;
          if (r < entry_cnt && heap_less(timer_heap[r], timer_heap[m])) m = r;
          if (m == i) break;
          tmp = timer_heap[i]; timer_heap[i] = timer_heap[m]; timer_heap[m] = tmp;
          i = m;
        end
      end
    end
    if (n == 0) begin
      expected_results.push_back(mk_result(KIND_NONE, '0, 1'b1));
      n_none++;
    end else begin
      last_r = expected_results.pop_back();
      last_r.last = 1'b1;
      expected_results.push_back(last_r);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_item(in_data_i);
        void'(pending_items.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: expected no result, actual %p", $time, out_data_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.kind !== exp_r.kind ||
              out_data_o.expired_key !== exp_r.expired_key ||
              out_data_o.expired_time !== exp_r.expired_time ||
              out_data_o.last !== exp_r.last) begin
            $display("%0t: expected %p actual %p", $time, exp_r, out_data_o);
            errors++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom, $urandom});
  endfunction

  function automatic in_item_t sched(logic [KeyW-1:0] k, logic [TimeW-1:0] t);
    in_item_t it;
    it.mode = MODE_SCHEDULE;
    it.key_handle = k;
    it.expire_time = t;
    it.current_time = rand_time();
    return it;
  endfunction

  function automatic in_item_t tick(logic [TimeW-1:0] t);
    in_item_t it;
    it.mode = MODE_TICK;
    it.key_handle = $urandom;
    it.expire_time = rand_time();
    it.current_time = t;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    logic [TimeW-1:0] base, now;
    int unsigned ph, j, burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_items.push_back(tick('0));
    pending_items.push_back(tick('1));
    pending_items.push_back(sched('1, '1));
    pending_items.push_back(sched('0, '0));
    pending_items.push_back(sched(32'd5, 48'd100));
    pending_items.push_back(sched(32'd3, 48'd100));
    pending_items.push_back(sched(32'd3, 48'd100));
    pending_items.push_back(sched(32'd7, 48'd50));
    pending_items.push_back(tick(48'd49));
    pending_items.push_back(tick(48'd100));
    pending_items.push_back(tick('1));
    for (j = 0; j < Cap + 2; j++) begin
      pending_items.push_back(sched($urandom, TimeW'($urandom_range(999))));
    end
    pending_items.push_back(tick('1));
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 9) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 79 : 9) : 0;
      if (ph == 3) begin send_idle_pct = 9; recv_stall_pct = 9; end
      base = rand_time() >> $urandom_range(40);
      now = base;
      j = 0;
      while (j < 70) begin
        if ($urandom_range(9) == 0) begin
          pending_items.push_back($urandom_range(1) ? tick(rand_time()) :
                                  sched($urandom, rand_time()));
          j++;
        end else begin
          burst = $urandom_range(1, ($urandom_range(5) == 0) ? 70 : 8);
          repeat (burst) begin
            pending_items.push_back(sched($urandom_range(3) == 0 ? $urandom_range(3) : $urandom,
                                          now + TimeW'($urandom_range(200))));
            j++;
          end
          now = now + TimeW'($urandom_range(150));
          pending_items.push_back(tick(now));
          j++;
        end
      end
      pending_items.push_back(tick('1));
      drain();
    end
    $display("Covered %0d accepted and %0d rejected schedules, %0d expiries, %0d empty ticks.",
             n_sched, n_reject, n_expired, n_none);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mhtq_pkg.sv
sv/min_heap_expiry_timer_queue_unit.sv
tb/sv/min_heap_expiry_timer_queue_unit_tb.sv
